>>> rtl/core/swrc_pkg.sv
// shared types and codes for the strong/weak reference slot table
`timescale 1ns / 1ps

package swrc_pkg;

    // operation codes on the func port
    localparam logic [2:0] FUNC_CREATE     = 3'd0;
    localparam logic [2:0] FUNC_ADD_STRONG = 3'd1;
    localparam logic [2:0] FUNC_ADD_WEAK   = 3'd2;
    localparam logic [2:0] FUNC_REM_STRONG = 3'd3;
    localparam logic [2:0] FUNC_REM_WEAK   = 3'd4;
    localparam logic [2:0] FUNC_READ       = 3'd5;

    // decoded operation as carried through the command queue
    typedef enum logic [2:0] {
        OP_CREATE,
        OP_ADD_STRONG,
        OP_ADD_WEAK,
        OP_REM_STRONG,
        OP_REM_WEAK,
        OP_READ,
        OP_EMPTY_REF,
        OP_NONE
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_SATURATED = 3'd2,
        ST_EMPTY_REF = 3'd3,
        ST_UNDERFLOW = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0]  result_slot;
        logic [63:0] handle_out;
        logic        release_object;
        logic        slot_freed;
        t_status     status;
    } t_result;

endpackage

>>> rtl/core/swrc_fifo.sv
// small first-in first-out queue of flat words
`timescale 1ns / 1ps

module swrc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [PW:0]      r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/core/swrc_front.sv
// front end: decodes an incoming operation and folds the slot index into range
`timescale 1ns / 1ps

module swrc_front #(
    parameter int SLOTS       = 256,
    parameter int HANDLE_BITS = 64
) (
    input  logic [2:0]               i_func,
    input  logic [7:0]               i_slot_index,
    input  logic                     i_ref_empty,
    input  logic [63:0]              i_new_handle,
    input  logic                     i_delete_object,
    output swrc_pkg::t_op            o_op,
    output logic [$clog2(SLOTS)-1:0] o_slot,
    output logic [HANDLE_BITS-1:0]   o_handle,
    output logic                     o_del
);

    localparam int IW = $clog2(SLOTS);

    // slot index modulo the table size, as a constant lookup over the 8-bit index
    logic [IW-1:0] slot_map [256];

    for (genvar k = 0; k < 256; k++) begin : g_slot_map
        assign slot_map[k] = IW'(k % SLOTS);
    end

    assign o_slot   = slot_map[i_slot_index];
    assign o_handle = i_new_handle[HANDLE_BITS-1:0];
    assign o_del    = i_delete_object;

    always_comb begin
        case (i_func)
            swrc_pkg::FUNC_CREATE:     o_op = swrc_pkg::OP_CREATE;
            swrc_pkg::FUNC_ADD_STRONG: o_op = swrc_pkg::OP_ADD_STRONG;
            swrc_pkg::FUNC_ADD_WEAK:   o_op = swrc_pkg::OP_ADD_WEAK;
            swrc_pkg::FUNC_REM_STRONG: o_op = swrc_pkg::OP_REM_STRONG;
            swrc_pkg::FUNC_REM_WEAK:   o_op = swrc_pkg::OP_REM_WEAK;
            swrc_pkg::FUNC_READ:       o_op = swrc_pkg::OP_READ;
            default:                   o_op = swrc_pkg::OP_NONE;
        endcase
        if (i_ref_empty && (i_func != swrc_pkg::FUNC_CREATE) && (o_op != swrc_pkg::OP_NONE)) begin
            o_op = swrc_pkg::OP_EMPTY_REF;
        end
    end

endmodule

>>> rtl/core/swrc_back.sv
// back end: slot memories, free stack and the read-modify-write sequencer
`timescale 1ns / 1ps

module swrc_back #(
    parameter int SLOTS       = 256,
    parameter int COUNT_BITS  = 16,
    parameter int HANDLE_BITS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_empty,
    output logic                     o_cmd_pop,
    input  swrc_pkg::t_op            i_op,
    input  logic [$clog2(SLOTS)-1:0] i_slot,
    input  logic [HANDLE_BITS-1:0]   i_handle,
    input  logic                     i_del,
    input  logic                     i_res_full,
    output logic                     o_res_push,
    output swrc_pkg::t_result        o_res
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW:0] SLOTS_W = (IW+1)'(SLOTS);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    // slot storage
    logic [HANDLE_BITS-1:0] r_handle_mem [SLOTS];
    logic [COUNT_BITS-1:0]  r_strong_mem [SLOTS];
    logic [COUNT_BITS-1:0]  r_weak_mem   [SLOTS];
    logic [IW-1:0]          r_stack_mem  [SLOTS];

    t_state                 r_state, n_state;
    logic [IW:0]            r_depth, n_depth;
    logic [IW:0]            r_used, n_used;

    // latched command and registered read data
    swrc_pkg::t_op          r_op;
    logic [IW-1:0]          r_slot;
    logic [HANDLE_BITS-1:0] r_hnd;
    logic                   r_del;
    logic [HANDLE_BITS-1:0] r_rd_handle;
    logic [COUNT_BITS-1:0]  r_rd_strong;
    logic [COUNT_BITS-1:0]  r_rd_weak;
    logic [IW-1:0]          r_rd_stack;

    logic [IW:0]            depth_m1;
    logic                   take, go;

    logic                   we_handle, we_strong, we_weak, we_stack;
    logic [IW-1:0]          wa_slot;
    logic [HANDLE_BITS-1:0] wd_handle;
    logic [COUNT_BITS-1:0]  wd_strong, wd_weak;
    logic [IW-1:0]          new_slot;
    logic                   got_slot;
    logic                   dead;
    logic [HANDLE_BITS-1:0] hout;
    logic [IW-1:0]          rslot;
    logic [HANDLE_BITS+63:0] hout_ext;
    logic [IW+7:0]          rslot_ext;
    swrc_pkg::t_result      res;

    assign depth_m1  = r_depth - 1'b1;
    assign take      = (r_state == S_IDLE) && !i_cmd_empty;
    assign go        = (r_state == S_EXEC) && !i_res_full;
    assign o_cmd_pop = take;
    assign o_res_push = go;
    assign o_res     = res;

    always_comb begin
        n_state   = r_state;
        n_depth   = r_depth;
        n_used    = r_used;
        we_handle = 1'b0;
        we_strong = 1'b0;
        we_weak   = 1'b0;
        we_stack  = 1'b0;
        wa_slot   = r_slot;
        wd_handle = '0;
        wd_strong = r_rd_strong;
        wd_weak   = r_rd_weak;
        new_slot  = '0;
        got_slot  = 1'b0;
        dead      = 1'b0;
        hout      = '0;
        rslot     = '0;
        hout_ext  = '0;
        rslot_ext = '0;
        res       = '0;

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                res.status = swrc_pkg::ST_OK;
                case (r_op)
                    swrc_pkg::OP_CREATE: begin
                        // most recently freed slot first, then a fresh one
                        if (r_depth != '0) begin
                            new_slot = r_rd_stack;
                            got_slot = 1'b1;
                            n_depth  = depth_m1;
                        end else if (r_used != SLOTS_W) begin
                            new_slot = r_used[IW-1:0];
                            got_slot = 1'b1;
                            n_used   = r_used + 1'b1;
                        end
                        if (got_slot) begin
                            wa_slot   = new_slot;
                            we_handle = 1'b1;
                            wd_handle = r_hnd;
                            we_strong = 1'b1;
                            wd_strong = COUNT_BITS'(1);
                            we_weak   = 1'b1;
                            wd_weak   = '0;
                            rslot     = new_slot;
                        end else begin
                            res.status = swrc_pkg::ST_FULL;
                        end
                    end
                    swrc_pkg::OP_ADD_STRONG: begin
                        rslot = r_slot;
                        if (r_rd_strong == '1) begin
                            res.status = swrc_pkg::ST_SATURATED;
                        end else begin
                            we_strong = 1'b1;
                            wd_strong = r_rd_strong + 1'b1;
                        end
                    end
                    swrc_pkg::OP_ADD_WEAK: begin
                        rslot = r_slot;
                        if (r_rd_weak == '1) begin
                            res.status = swrc_pkg::ST_SATURATED;
                        end else begin
                            we_weak = 1'b1;
                            wd_weak = r_rd_weak + 1'b1;
                        end
                    end
                    swrc_pkg::OP_REM_STRONG: begin
                        rslot = r_slot;
                        if (r_rd_strong == '0) begin
                            res.status = swrc_pkg::ST_UNDERFLOW;
                        end else begin
                            // last strong reference drops the handle
                            if (r_rd_strong == COUNT_BITS'(1)) begin
                                we_handle = 1'b1;
                                wd_handle = '0;
                                if (r_del) begin
                                    hout               = r_rd_handle;
                                    res.release_object = 1'b1;
                                end
                            end
                            we_strong = 1'b1;
                            wd_strong = r_rd_strong - 1'b1;
                            dead      = (wd_strong == '0) && (r_rd_weak == '0);
                        end
                    end
                    swrc_pkg::OP_REM_WEAK: begin
                        rslot = r_slot;
                        if (r_rd_weak == '0) begin
                            res.status = swrc_pkg::ST_UNDERFLOW;
                        end else begin
                            we_weak = 1'b1;
                            wd_weak = r_rd_weak - 1'b1;
                            dead    = (wd_weak == '0) && (r_rd_strong == '0);
                        end
                    end
                    swrc_pkg::OP_READ: begin
                        rslot = r_slot;
                        hout  = r_rd_handle;
                    end
                    swrc_pkg::OP_EMPTY_REF: begin
                        res.status = swrc_pkg::ST_EMPTY_REF;
                    end
                    default: begin
                    end
                endcase

                // dead slot goes back on the free stack if there is room
                if (dead && (r_depth != SLOTS_W)) begin
                    we_stack       = 1'b1;
                    n_depth        = r_depth + 1'b1;
                    res.slot_freed = 1'b1;
                end

                hout_ext        = {64'b0, hout};
                rslot_ext       = {8'b0, rslot};
                res.handle_out  = hout_ext[63:0];
                res.result_slot = rslot_ext[7:0];

                if (!go) begin
                    we_handle = 1'b0;
                    we_strong = 1'b0;
                    we_weak   = 1'b0;
                    we_stack  = 1'b0;
                    n_depth   = r_depth;
                    n_used    = r_used;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_op   <= i_op;
            r_slot <= i_slot;
            r_hnd  <= i_handle;
            r_del  <= i_del;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_handle) begin
            r_handle_mem[wa_slot] <= wd_handle;
        end
        if (take) begin
            r_rd_handle <= r_handle_mem[i_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_strong) begin
            r_strong_mem[wa_slot] <= wd_strong;
        end
        if (take) begin
            r_rd_strong <= r_strong_mem[i_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_weak) begin
            r_weak_mem[wa_slot] <= wd_weak;
        end
        if (take) begin
            r_rd_weak <= r_weak_mem[i_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_stack) begin
            r_stack_mem[r_depth[IW-1:0]] <= r_slot;
        end
        if (take) begin
            r_rd_stack <= r_stack_mem[depth_m1[IW-1:0]];
        end
    end

endmodule

>>> rtl/core/strong_weak_refcount_table.sv
// top level of the strong/weak reference slot table
`timescale 1ns / 1ps

// reference slot table: each slot holds a handle, a strong count and a weak count
// - operations come in through a queue-like port: an operation transfers on a rising
//   edge with push high and full low; func selects create, add/remove strong or weak,
//   or read handle
// - results leave the same way: while empty is low the oldest result sits on the
//   o_ ports and transfers on an edge with pop high
// - every operation yields exactly one result, in order
// - in the back end an operation is first latched while the slot and the free-stack
//   top are read from the memories, then in S_EXEC they are updated and the result is
//   emitted, held back while the result queue is full; the next operation is taken
//   only after that result has been emitted
// - a two-entry command queue sits between decode and the back end, and a two-entry
//   result queue at the output, so a stalled reader only blocks once both fill up
// - reset clears the free-stack depth, the never-used slot counter and both queues;
//   slot contents are not cleared and need no clearing pass: the user must see that
//   create writes every slot before any operation names it; the block does not check
// - table full, count saturation and underflow are reported in o_status and leave
//   the table unchanged
module strong_weak_refcount_table #(
    parameter int SLOTS       = 256,
    parameter int COUNT_BITS  = 16,
    parameter int HANDLE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // operation channel
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_slot_index,
    input  logic        i_ref_empty,
    input  logic [63:0] i_new_handle,
    input  logic        i_delete_object,
    // result channel
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_result_slot,
    output logic [63:0] o_handle_out,
    output logic        o_release_object,
    output logic        o_slot_freed,
    output logic [2:0]  o_status
);

    localparam int IW     = $clog2(SLOTS);
    localparam int CMD_W  = 3 + IW + HANDLE_BITS + 1;
    localparam int RES_W  = $bits(swrc_pkg::t_result);

    // decoded command from the front end
    swrc_pkg::t_op          fe_op;
    logic [IW-1:0]          fe_slot;
    logic [HANDLE_BITS-1:0] fe_handle;
    logic                   fe_del;
    logic [CMD_W-1:0]       fe_word;

    // command queue output toward the back end
    logic [CMD_W-1:0]       cq_word;
    logic                   cq_empty;
    logic                   cq_pop;
    swrc_pkg::t_op          be_op;
    logic [IW-1:0]          be_slot;
    logic [HANDLE_BITS-1:0] be_handle;
    logic                   be_del;

    // result path
    swrc_pkg::t_result      be_res;
    logic                   be_res_push;
    logic                   rq_full;
    logic [RES_W-1:0]       rq_word;
    swrc_pkg::t_result      out_res;

    swrc_front #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_front (
        .i_func          (i_func),
        .i_slot_index    (i_slot_index),
        .i_ref_empty     (i_ref_empty),
        .i_new_handle    (i_new_handle),
        .i_delete_object (i_delete_object),
        .o_op            (fe_op),
        .o_slot          (fe_slot),
        .o_handle        (fe_handle),
        .o_del           (fe_del)
    );

    assign fe_word = {fe_op, fe_slot, fe_handle, fe_del};

    // decoupling queue between decode and execution
    swrc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (fe_word),
        .o_full  (full),
        .i_pop   (cq_pop),
        .o_data  (cq_word),
        .o_empty (cq_empty)
    );

    assign be_op     = swrc_pkg::t_op'(cq_word[CMD_W-1 -: 3]);
    assign be_slot   = cq_word[HANDLE_BITS+IW : HANDLE_BITS+1];
    assign be_handle = cq_word[HANDLE_BITS:1];
    assign be_del    = cq_word[0];

    swrc_back #(
        .SLOTS       (SLOTS),
        .COUNT_BITS  (COUNT_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cq_empty),
        .o_cmd_pop   (cq_pop),
        .i_op        (be_op),
        .i_slot      (be_slot),
        .i_handle    (be_handle),
        .i_del       (be_del),
        .i_res_full  (rq_full),
        .o_res_push  (be_res_push),
        .o_res       (be_res)
    );

    // result queue keeps the back end running while the reader stalls
    swrc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (be_res_push),
        .i_data  (be_res),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_data  (rq_word),
        .o_empty (empty)
    );

    assign out_res          = swrc_pkg::t_result'(rq_word);
    assign o_result_slot    = out_res.result_slot;
    assign o_handle_out     = out_res.handle_out;
    assign o_release_object = out_res.release_object;
    assign o_slot_freed     = out_res.slot_freed;
    assign o_status         = out_res.status;

endmodule
